>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the odd-even merge sorter.
// No dependencies; synthesis builds see empty macro bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication checked at every clock edge out of reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
// Next-cycle implication checked at every clock edge out of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/oems_pkg.sv
// Shared types and constants of the odd-even merge sorter.
// No dependencies; used by the cell, the controller and the top level.
package oems_pkg;

   localparam int KEY_W = 32;

   // Cell mode: neither bit set means insert (compare and pass on).
   typedef struct packed {
      logic shift_left;
      logic shift_right;
   } cell_ctl_type;

   // Controller states, one-hot.
   typedef enum logic [2:0] {
      ST_LOAD  = 3'b001,
      ST_FLUSH = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

endpackage

>>> sv/oems_cell.sv
// One sorting cell: keeps the smaller key, passes the other on, or shifts.
// Depends on oems_pkg for the key width and the cell control struct.
module oems_cell
   import oems_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cell_ctl_type            ctl,
   input  logic                    in_valid,
   input  logic signed [KEY_W-1:0] in_key,
   input  logic                    left_valid,
   input  logic signed [KEY_W-1:0] left_key,
   input  logic                    right_valid,
   input  logic signed [KEY_W-1:0] right_key,
   output logic                    pass_valid,
   output logic signed [KEY_W-1:0] pass_key,
   output logic                    held_valid,
   output logic signed [KEY_W-1:0] held_key
);

   logic                    held_valid_ff, held_valid_in;
   logic signed [KEY_W-1:0] held_key_ff, held_key_in;
   logic                    pass_valid_ff, pass_valid_in;
   logic signed [KEY_W-1:0] pass_key_ff, pass_key_in;
   logic                    take_in;

   // An empty cell counts as larger than any key.
   assign take_in = in_valid && (!held_valid_ff || (in_key < held_key_ff));

   // Insert, or shift the held keys one place during output.
   always_comb begin
      held_valid_in = held_valid_ff;
      held_key_in   = held_key_ff;
      pass_valid_in = 1'b0;
      pass_key_in   = in_key;
      if (ctl.shift_left) begin
         held_valid_in = right_valid;
         held_key_in   = right_key;
      end else if (ctl.shift_right) begin
         held_valid_in = left_valid;
         held_key_in   = left_key;
      end else if (take_in) begin
         held_valid_in = 1'b1;
         held_key_in   = in_key;
         pass_valid_in = held_valid_ff;
         pass_key_in   = held_key_ff;
      end else begin
         pass_valid_in = in_valid;
      end
   end

   // Valid bits reset; keys need none.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         pass_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         pass_valid_ff <= pass_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_key_ff <= held_key_in;
      pass_key_ff <= pass_key_in;
   end

   assign pass_valid = pass_valid_ff;
   assign pass_key   = pass_key_ff;
   assign held_valid = held_valid_ff;
   assign held_key   = held_key_ff;

endmodule

>>> sv/oems_ctrl.sv
// Sequencer of the sorter: load, flush of the cell row, and output.
// Depends on oems_pkg for the state type and the cell control struct.
module oems_ctrl
   import oems_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         last_in,
   input  logic         csr_valid,
   input  logic         csr_descending,
   input  logic         head_valid,
   output logic         busy,
   output logic         accept,
   output logic         csr_ready,
   output cell_ctl_type ctl,
   output logic         out_desc,
   output logic         emit,
   output logic         emit_last,
   output state_type    state
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             desc_ff, desc_in;
   logic             out_desc_ff, out_desc_in;
   logic             done_load;

   assign busy      = (state_ff != ST_LOAD);
   assign accept    = start && !busy;
   assign csr_ready = !busy;
   assign done_load = accept && (last_in || (fill_ff == CNT_W'(DEPTH - 1)));
   assign emit      = (state_ff == ST_DRAIN) && head_valid;
   assign emit_last = emit && (count_ff == CNT_W'(1));

   // Next state and counters.
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      count_in    = count_ff;
      desc_in     = desc_ff;
      out_desc_in = out_desc_ff;
      ctl         = '0;
      if (csr_valid && csr_ready) begin
         desc_in = csr_descending;
      end
      unique case (state_ff)
         ST_LOAD: begin
            if (done_load) begin
               // Count holds the flush length, the fill count the batch size.
               state_in    = ST_FLUSH;
               fill_in     = fill_ff + CNT_W'(1);
               count_in    = CNT_W'(DEPTH);
               out_desc_in = desc_ff;
            end else if (accept) begin
               fill_in = fill_ff + CNT_W'(1);
            end
         end
         ST_FLUSH: begin
            count_in = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               state_in = ST_DRAIN;
               count_in = fill_ff;
            end
         end
         ST_DRAIN: begin
            ctl.shift_left  = !out_desc_ff;
            ctl.shift_right = out_desc_ff;
            if (emit) begin
               count_in = count_ff - CNT_W'(1);
            end
            if (emit_last) begin
               state_in = ST_LOAD;
               fill_in  = '0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         fill_ff     <= '0;
         count_ff    <= '0;
         desc_ff     <= 1'b0;
         out_desc_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         count_ff    <= count_in;
         desc_ff     <= desc_in;
         out_desc_ff <= out_desc_in;
      end
   end

   assign out_desc = out_desc_ff;
   assign state    = state_ff;

endmodule

>>> sv/block_odd_even_merge_sorter.sv
// Batch sorter over a row of DEPTH = BLOCKS*BLOCK_LEN cells; one request loads per cycle
// while not busy. After the request that ends a batch of n keys the row flushes, then emits
// one key per cycle: ascending from the first cell, descending from the far end once the
// keys have shifted there; busy drops in the cycle the last result is on the ports. The
// receiver cannot stall.
// Synchronous reset empties the row and selects ascending order.
`include "assert_macros.svh"

module block_odd_even_merge_sorter
   import oems_pkg::*;
#(
   parameter int BLOCKS    = 8,
   parameter int BLOCK_LEN = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [KEY_W-1:0] req_key,
   input  logic                    req_last_in,
   output logic                    rsp_strobe,
   output logic signed [KEY_W-1:0] rsp_sorted_key,
   output logic                    rsp_last_out,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_descending
);

   localparam int DEPTH = BLOCKS * BLOCK_LEN;

   cell_ctl_type            ctl;
   state_type               state;
   logic                    accept;
   logic                    out_desc;
   logic                    emit;
   logic                    emit_last;
   logic                    head_valid;
   logic signed [KEY_W-1:0] head_key;

   logic                    in_v   [DEPTH+1];
   logic signed [KEY_W-1:0] in_k   [DEPTH+1];
   logic                    held_v [DEPTH+2];
   logic signed [KEY_W-1:0] held_k [DEPTH+2];

   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic                    rsp_last_ff;
   logic signed [KEY_W-1:0] rsp_key_ff;

   oems_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .last_in        (req_last_in),
      .csr_valid      (csr_valid),
      .csr_descending (csr_descending),
      .head_valid     (head_valid),
      .busy           (busy),
      .accept         (accept),
      .csr_ready      (csr_ready),
      .ctl            (ctl),
      .out_desc       (out_desc),
      .emit           (emit),
      .emit_last      (emit_last),
      .state          (state)
   );

   // New keys enter the first cell; the row ends are empty neighbors.
   assign in_v[0]          = accept;
   assign in_k[0]          = req_key;
   assign held_v[0]        = 1'b0;
   assign held_k[0]        = '0;
   assign held_v[DEPTH+1]  = 1'b0;
   assign held_k[DEPTH+1]  = '0;

   // Cell i sits at slot i+1 of the held arrays so both ends have a neighbor.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      oems_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .in_valid    (in_v[i]),
         .in_key      (in_k[i]),
         .left_valid  (held_v[i]),
         .left_key    (held_k[i]),
         .right_valid (held_v[i+2]),
         .right_key   (held_k[i+2]),
         .pass_valid  (in_v[i+1]),
         .pass_key    (in_k[i+1]),
         .held_valid  (held_v[i+1]),
         .held_key    (held_k[i+1])
      );
   end

   // Ascending output leaves from the first cell, descending from the last.
   assign head_valid = out_desc ? held_v[DEPTH] : held_v[1];
   assign head_key   = out_desc ? held_k[DEPTH] : held_k[1];

   // Result registers.
   assign rsp_strobe_in = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_key_ff  <= head_key;
      rsp_last_ff <= emit_last;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_sorted_key = rsp_key_ff;
   assign rsp_last_out   = rsp_last_ff && rsp_strobe_ff;

   // The last result of a batch is never followed directly by another.
   `ASSERT_NEXT(a_last_gap, clock, reset, rsp_last_out, !rsp_strobe)
   // A request that closes the batch makes the block busy.
   `ASSERT_NEXT(a_close_busy, clock, reset, accept && req_last_in, busy)
   // Results are only produced while draining, and the row is not fed then.
   `ASSERT_IMPLIES(a_emit_drain, clock, reset, emit, (state == ST_DRAIN) && !in_v[0])
   // Cells shift only while draining.
   `ASSERT_IMPLIES(a_shift_drain, clock, reset, ctl.shift_left || ctl.shift_right,
                   state == ST_DRAIN)

endmodule
